>>> rtl/core/rmsd_pkg.sv
// Shared constants, types and sequencer states for the running mean and deviation block.
package rmsd_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int SAMPLE_W    = 24;

  localparam int SMP_W   = 24;              // port width of a sample and of the mean
  localparam int SD_W    = 24;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 63;
  localparam int PROD_W  = 80;              // n*Q and S*S both stay below 2^79
  localparam int ACC_W   = PROD_W + 1;      // one spare bit for borrow
  localparam int DVS_W   = 32;              // n*(n-1) is below 2^32
  localparam int REM_W   = DVS_W + 1;
  localparam int ROOT_W  = 48;              // radicand width; wider quotients saturate
  localparam int SQRT_STEPS = ROOT_W / 2;
  localparam int STEP_W  = $clog2(PROD_W);
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MEAN_DIV,
    E_MEAN_FIX,
    E_MUL_Q,
    E_MUL_S,
    E_VAR_DIV,
    E_SQRT,
    E_DONE
  } eng_state_t;

  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_op_t;

  typedef struct packed {
    logic start;
    logic sink_free;
  } eng_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SMP_W-1:0] mean;
    logic [SD_W-1:0]  sd;
  } eng_rsp_t;

endpackage

>>> rtl/core/rmsd_alu.sv
// Shared wide add/subtract unit used by the division, multiply and square-root steps of the statistics sequencer.
module rmsd_alu import rmsd_pkg::*; (
  input  alu_op_t          op,
  output logic [ACC_W-1:0] y
);

  // For a subtract of two values below 2^80, the top bit is the borrow.
  assign y = op.sub ? (op.a - op.b) : (op.a + op.b);

endmodule

>>> rtl/core/rmsd_engine.sv
// Sequencer that computes mean and sample deviation through the shared add/subtract unit.
module rmsd_engine import rmsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  eng_req_t                req,
  input  logic [CNT_W-1:0]        n,
  input  logic signed [SUM_W-1:0] s,
  input  logic [SQ_W-1:0]         q,
  output eng_rsp_t                rsp
);

  eng_state_t        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [PROD_W-1:0] mcand, mcand_next;
  logic [ROOT_W-1:0] mplier, mplier_next;
  logic [REM_W-1:0]  rem, rem_next;
  logic [DVS_W-1:0]  dvsr, dvsr_next;
  logic [ROOT_W-1:0] quot, quot_next;
  logic              ovf, ovf_next;
  logic              neg, neg_next;
  logic [SMP_W-1:0]  mean, mean_next;
  logic [SD_W-1:0]   sd, sd_next;

  alu_op_t           op;
  logic [ACC_W-1:0]  y;
  logic              borrow;
  logic [SUM_W-1:0]  smag;
  logic [REM_W:0]    trial;
  logic              fits;
  logic [2*CNT_W-1:0] pair;
  logic [SMP_W-1:0]  qmean;
  logic [ROOT_W-1:0] root_try;

  rmsd_alu u_alu (
    .op (op),
    .y  (y)
  );

  assign borrow   = y[ACC_W-1];
  assign smag     = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
  assign trial    = {rem, acc[PROD_W-1]};
  assign fits     = !borrow;
  assign pair     = n * (n - CNT_W'(1));
  assign qmean    = quot[SMP_W-1:0] + SMP_W'(neg && (rem != '0));
  assign root_try = mcand[ROOT_W-1:0] | mplier;

  always_comb begin
    unique case (state)
      E_MEAN_DIV, E_VAR_DIV: begin
        op = '{a: ACC_W'(trial), b: ACC_W'(dvsr), sub: 1'b1};
      end
      E_MUL_Q: op = '{a: acc, b: ACC_W'(mcand), sub: 1'b0};
      E_MUL_S: op = '{a: acc, b: ACC_W'(mcand), sub: 1'b1};
      E_SQRT:  op = '{a: ACC_W'(quot), b: ACC_W'(root_try), sub: 1'b1};
      default: op = '{a: acc, b: '0, sub: 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt    <= cnt_next;
    acc    <= acc_next;
    mcand  <= mcand_next;
    mplier <= mplier_next;
    rem    <= rem_next;
    dvsr   <= dvsr_next;
    quot   <= quot_next;
    ovf    <= ovf_next;
    neg    <= neg_next;
    mean   <= mean_next;
    sd     <= sd_next;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt - STEP_W'(1);
    acc_next    = acc;
    mcand_next  = mcand;
    mplier_next = mplier;
    rem_next    = rem;
    dvsr_next   = dvsr;
    quot_next   = quot;
    ovf_next    = ovf;
    neg_next    = neg;
    mean_next   = mean;
    sd_next     = sd;

    unique case (state)
      E_IDLE: begin
        if (req.start) begin
          if (n < CNT_W'(2)) begin
            // No samples gives all zeros; a single sample is its own mean.
            mean_next  = (n == CNT_W'(1)) ? s[SMP_W-1:0] : '0;
            sd_next    = '0;
            state_next = E_DONE;
          end else begin
            neg_next   = s[SUM_W-1];
            acc_next   = {1'b0, smag, {(PROD_W-SUM_W){1'b0}}};
            rem_next   = '0;
            dvsr_next  = DVS_W'(n);
            quot_next  = '0;
            cnt_next   = STEP_W'(SUM_W - 1);
            state_next = E_MEAN_DIV;
          end
        end
      end

      E_MEAN_DIV, E_VAR_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_next  = fits ? y[REM_W-1:0] : trial[REM_W-1:0];
        acc_next  = acc << 1;
        quot_next = {quot[ROOT_W-2:0], fits};
        ovf_next  = ovf | quot[ROOT_W-1];
        if (cnt == '0) begin
          if (state == E_MEAN_DIV) begin
            state_next = E_MEAN_FIX;
          end else begin
            mcand_next  = '0;
            mplier_next = ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
            cnt_next    = STEP_W'(SQRT_STEPS - 1);
            state_next  = E_SQRT;
          end
        end
      end

      E_MEAN_FIX: begin
        // Floor of a negative quotient rounds the magnitude up.
        mean_next   = neg ? (~qmean + SMP_W'(1)) : qmean;
        acc_next    = '0;
        mcand_next  = PROD_W'(q);
        mplier_next = ROOT_W'(n);
        dvsr_next   = pair[DVS_W-1:0];
        cnt_next    = STEP_W'(CNT_W - 1);
        state_next  = E_MUL_Q;
      end

      E_MUL_Q: begin
        if (mplier[0]) begin
          acc_next = y;
        end
        mcand_next  = mcand << 1;
        mplier_next = mplier >> 1;
        if (cnt == '0) begin
          mcand_next  = PROD_W'(smag);
          mplier_next = ROOT_W'(smag);
          cnt_next    = STEP_W'(SUM_W - 1);
          state_next  = E_MUL_S;
        end
      end

      E_MUL_S: begin
        if (mplier[0]) begin
          acc_next = y;
        end
        mcand_next  = mcand << 1;
        mplier_next = mplier >> 1;
        if (cnt == '0) begin
          // A negative spread is taken as zero.
          if (acc_next[ACC_W-1]) begin
            acc_next = '0;
          end
          rem_next   = '0;
          quot_next  = '0;
          ovf_next   = 1'b0;
          cnt_next   = STEP_W'(PROD_W - 1);
          state_next = E_VAR_DIV;
        end
      end

      E_SQRT: begin
        // Digit-by-digit square root; the root and the test bit never overlap.
        if (fits) begin
          quot_next  = y[ROOT_W-1:0];
          mcand_next = PROD_W'((mcand[ROOT_W-1:0] >> 1) | mplier);
        end else begin
          mcand_next = PROD_W'(mcand[ROOT_W-1:0] >> 1);
        end
        mplier_next = mplier >> 2;
        if (cnt == '0) begin
          sd_next    = ovf ? '1 : mcand_next[SD_W-1:0];
          state_next = E_DONE;
        end
      end

      E_DONE: begin
        if (req.sink_free) begin
          state_next = E_IDLE;
        end
      end

      default: state_next = E_IDLE;
    endcase
  end

  assign rsp = '{busy: (state != E_IDLE),
                 done: (state == E_DONE) && req.sink_free,
                 mean: mean,
                 sd:   sd};

endmodule

>>> rtl/core/running_mean_sample_stdev.sv
// Top level: sample accumulation, stream handshakes and result register of the statistics block.
//
// Samples arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser). Each transaction
// carries one 24-bit signed sample in s_tdata and three flags in s_tuser: sample_valid adds
// the sample to the count, sum and sum of squares; report asks for one result covering every
// sample so far, this one included; clear zeroes the sums after that result. Once the count
// reaches MAX_SAMPLES further samples are ignored.
// Transactions without report stream at one per clock while no report is pending or in work.
// A report with two or more samples runs the mean division (40 steps), n*Q (17 steps),
// S*S (40 steps), the variance division (80 steps) and the square root (24 steps) on one
// shared 81-bit add/subtract unit; with fewer samples it goes straight to the result.
// s_tready stays low from the report until the result is handed to the output register.
// Results leave on the master stream (m_tvalid, m_tready, m_tdata) from an output register.
// While a result waits for m_tready, new samples are still taken; a further report finishes
// its arithmetic and then holds until the register is free.
// Reset (rst, synchronous, active high) empties the accumulators and drops any result.
module running_mean_sample_stdev import rmsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [23:0] sample
  input  logic [IN_USER_W-1:0]  s_tuser,   // [0] sample_valid, [1] report, [2] clear
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [23:0] mean_value, [47:24] std_dev,
                                           // [64:48] sample_count, [71:65] zero
);

  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] running_sum;
  logic [SQ_W-1:0]         running_sum_of_squares;
  logic                    pending;
  logic                    clear_hold;

  logic signed [SAMPLE_W-1:0] sample_raw;
  logic signed [SMP_W-1:0]    sample_x;
  logic signed [2*SMP_W-1:0]  sample_sq;
  logic                       accept;
  logic                       add_ok;

  eng_req_t req;
  eng_rsp_t rsp;

  // Only the low SAMPLE_W bits count, sign-extended from the top one.
  assign sample_raw = s_tdata[SAMPLE_W-1:0];
  assign sample_x   = SMP_W'(sample_raw);
  assign sample_sq  = sample_x * sample_x;

  assign s_tready = !pending && !rsp.busy;
  assign accept   = s_tvalid && s_tready;
  assign add_ok   = s_tuser[0] && (count < CNT_W'(MAX_SAMPLES));

  // The engine starts the cycle after the report, once the sums include its sample.
  assign req.start     = pending;
  assign req.sink_free = !m_tvalid || m_tready;

  rmsd_engine u_engine (
    .clk (clk),
    .rst (rst),
    .req (req),
    .n   (count),
    .s   (running_sum),
    .q   (running_sum_of_squares),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count                  <= '0;
      running_sum            <= '0;
      running_sum_of_squares <= '0;
      pending                <= 1'b0;
      clear_hold             <= 1'b0;
    end else begin
      pending <= 1'b0;
      if (accept) begin
        if (s_tuser[2] && !s_tuser[1]) begin
          // Clear with no report: whatever this item adds is dropped at once.
          count                  <= '0;
          running_sum            <= '0;
          running_sum_of_squares <= '0;
        end else if (add_ok) begin
          count                  <= count + CNT_W'(1);
          running_sum            <= running_sum + SUM_W'(sample_x);
          running_sum_of_squares <= running_sum_of_squares + SQ_W'(unsigned'(sample_sq));
        end
        if (s_tuser[1]) begin
          pending    <= 1'b1;
          clear_hold <= s_tuser[2];
        end
      end else if (rsp.done && clear_hold) begin
        // The report has been taken into the output register; now apply its clear.
        count                  <= '0;
        running_sum            <= '0;
        running_sum_of_squares <= '0;
        clear_hold             <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      m_tdata <= {(OUT_DATA_W - SMP_W - SD_W - CNT_W)'(0), count, rsp.sd, rsp.mean};
    end
  end

endmodule
